### rtl/proximity_falloff_dmx_level_macros.svh
// Assertion helpers for the RTL; the queue includes them.
`ifndef PROXIMITY_FALLOFF_DMX_LEVEL_MACROS_SVH
`define PROXIMITY_FALLOFF_DMX_LEVEL_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while in reset.
`define PFDL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while in reset.
`define PFDL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pfdl_pkg.sv
package pfdl_pkg;

    localparam int COORD_W   = 16;
    localparam int CHAN_W    = 9;
    localparam int LEVEL_W   = 8;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int D2_W      = SQ_W + 2;
    localparam int SCALE_W   = 16;
    localparam int SCALED_W  = D2_W + SCALE_W;
    localparam int R2_W      = 2 * COORD_W;
    localparam int LSQ_W     = 2 * LEVEL_W;
    localparam int PROD_W    = R2_W + LSQ_W;
    localparam int CFG_IDX_W = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    // 255 squared: the distance is scaled by this before the level search.
    localparam logic [SCALE_W-1:0] LEVEL_SCALE = 16'd65025;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_RADIUS = 3'd3;

    typedef struct packed {
        logic [SCALED_W-1:0] scaled;
        logic [CHAN_W-1:0]   channel;
        logic                zero;
    } pfdl_item_t;

endpackage

### rtl/pfdl_front.sv
module pfdl_front import pfdl_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] fx,
    input  logic signed [COORD_W-1:0] fy,
    input  logic signed [COORD_W-1:0] fz,
    input  logic        [CHAN_W-1:0]  fch,
    input  logic signed [COORD_W-1:0] tx,
    input  logic signed [COORD_W-1:0] ty,
    input  logic signed [COORD_W-1:0] tz,
    input  logic        [COORD_W-1:0] radius,
    output logic                      out_valid,
    input  logic                      out_ready,
    output pfdl_item_t                out_item
);

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic [COORD_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [SQ_W-1:0]    sx_reg, sy_reg, sz_reg;
    logic [D2_W-1:0]    d2_reg;
    logic [CHAN_W-1:0]  ch1_reg, ch2_reg, ch3_reg;
    logic               z1_reg, z2_reg, z3_reg;
    pfdl_item_t         item_reg;

    // Absolute difference of two signed values, done on offset-binary forms.
    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        logic [COORD_W-1:0] p;
        logic [COORD_W-1:0] q;
        p = {~a[COORD_W-1], a[COORD_W-2:0]};
        q = {~b[COORD_W-1], b[COORD_W-2:0]};
        return (p >= q) ? (p - q) : (q - p);
    endfunction

    assign en        = !v4_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = v4_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg  <= abs_diff(fx, tx);
            dy_reg  <= abs_diff(fy, ty);
            dz_reg  <= abs_diff(fz, tz);
            ch1_reg <= fch;
            z1_reg  <= (radius == '0);

            sx_reg  <= dx_reg * dx_reg;
            sy_reg  <= dy_reg * dy_reg;
            sz_reg  <= dz_reg * dz_reg;
            ch2_reg <= ch1_reg;
            z2_reg  <= z1_reg;

            d2_reg  <= D2_W'(sx_reg) + D2_W'(sy_reg) + D2_W'(sz_reg);
            ch3_reg <= ch2_reg;
            z3_reg  <= z2_reg;

            item_reg.scaled  <= SCALED_W'(d2_reg) * SCALED_W'(LEVEL_SCALE);
            item_reg.channel <= ch3_reg;
            item_reg.zero    <= z3_reg;
        end
    end

endmodule

### rtl/pfdl_queue.sv
module pfdl_queue import pfdl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  pfdl_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output pfdl_item_t out_item
);

`include "proximity_falloff_dmx_level_macros.svh"

    pfdl_item_t         mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               push, pop;

    assign in_ready  = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `PFDL_ASSERT_NOW(a_q_bound, 1'b1, count_reg <= Q_CNT_W'(Q_DEPTH), "queue count past depth")
    `PFDL_ASSERT_NEXT(a_q_fill, push && !pop, count_reg == $past(count_reg) + 1'b1, "fill lost")
    `PFDL_ASSERT_NEXT(a_q_drain, pop && !push, count_reg == $past(count_reg) - 1'b1, "drain lost")

endmodule

### rtl/pfdl_back.sv
module pfdl_back import pfdl_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  pfdl_item_t         in_item,
    input  logic [R2_W-1:0]    r2,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAN_W-1:0]  out_channel,
    output logic [LEVEL_W-1:0] out_level
);

    typedef struct packed {
        logic [SCALED_W-1:0] scaled;
        logic [CHAN_W-1:0]   channel;
        logic                zero;
        logic [LEVEL_W-1:0]  level;
    } ctx_t;

    logic en;
    logic va_reg [LEVEL_W];
    logic vb_reg [LEVEL_W];
    ctx_t ca_reg [LEVEL_W];
    ctx_t cb_reg [LEVEL_W];
    logic [LEVEL_W-1:0] cand_reg [LEVEL_W];
    logic [LSQ_W-1:0]   sq_reg   [LEVEL_W];

    assign en          = !vb_reg[LEVEL_W-1] || out_ready;
    assign in_ready    = en;
    assign out_valid   = vb_reg[LEVEL_W-1];
    assign out_channel = cb_reg[LEVEL_W-1].channel;
    assign out_level   = cb_reg[LEVEL_W-1].level;

    // One level bit per stage pair, most significant first: the first stage
    // squares 255 minus the candidate, the second scales it by r squared and
    // keeps the bit if the scaled distance still fits.
    for (genvar i = 0; i < LEVEL_W; i++) begin : g_bit
        logic               v_in;
        ctx_t               c_in;
        ctx_t               cb_next;
        logic [LEVEL_W-1:0] cand;
        logic [LEVEL_W-1:0] inv;
        logic [PROD_W-1:0]  prod;
        logic               fits;

        if (i == 0) begin : g_first
            assign v_in = in_valid;
            always_comb begin
                c_in.scaled  = in_item.scaled;
                c_in.channel = in_item.channel;
                c_in.zero    = in_item.zero;
                c_in.level   = '0;
            end
        end else begin : g_next
            assign v_in = vb_reg[i-1];
            assign c_in = cb_reg[i-1];
        end

        assign cand = c_in.level | (LEVEL_W'(1) << (LEVEL_W - 1 - i));
        assign inv  = ~cand;
        assign prod = PROD_W'(sq_reg[i]) * PROD_W'(r2);
        assign fits = !ca_reg[i].zero && (ca_reg[i].scaled <= SCALED_W'(prod));

        always_comb begin
            cb_next = ca_reg[i];
            if (fits) begin
                cb_next.level = cand_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                va_reg[i] <= 1'b0;
                vb_reg[i] <= 1'b0;
            end else if (en) begin
                va_reg[i] <= v_in;
                vb_reg[i] <= va_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ca_reg[i]   <= c_in;
                cand_reg[i] <= cand;
                sq_reg[i]   <= inv * inv;
                cb_reg[i]   <= cb_next;
            end
        end
    end

endmodule

### rtl/proximity_falloff_dmx_level.sv
// Proximity falloff DMX level.
// Each input item is one fixture (signed Q8.8 x, y, z and a 9-bit DMX
// channel). Each result item carries the channel back with a brightness
// level: floor(255 * (r - d) / r) for a fixture at distance d within the
// trigger sphere of radius r, and 0 outside it or when r is zero.
// Both channels use valid/ready; an item moves when both are high.
// Trigger centre and radius are written through cfg_wr_en, cfg_index and
// cfg_data; the user must write them only while no item is in flight,
// which the block itself does not enforce; indexes beyond the radius are
// ignored. An accepted item passes four front stages for distance and
// scaling, the queue, and sixteen back stages (two per level bit) for the
// level search. Throughput is one item per cycle while nothing stalls,
// set by the fully pipelined multipliers. Reset (aresetn low, synchronous)
// empties the pipeline and queue and loads centre 0 and radius 1.0 m. When
// the receiver stalls, the back pipeline holds, the four-entry queue fills,
// and only then does the front hold and drop s_ready.
module proximity_falloff_dmx_level import pfdl_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic        [CFG_IDX_W-1:0] cfg_index,
    input  logic        [COORD_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [COORD_W-1:0]   s_fixture_x,
    input  logic signed [COORD_W-1:0]   s_fixture_y,
    input  logic signed [COORD_W-1:0]   s_fixture_z,
    input  logic        [CHAN_W-1:0]    s_fixture_channel,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic        [CHAN_W-1:0]    m_out_channel,
    output logic        [LEVEL_W-1:0]   m_dmx_level
);

    logic signed [COORD_W-1:0] trig_x_reg, trig_y_reg, trig_z_reg;
    logic        [COORD_W-1:0] radius_reg;
    // The radius squared follows the radius in the next cycle; it is settled
    // long before any item reaches the level search.
    logic        [R2_W-1:0]    r2_reg;

    logic       fq_valid, fq_ready, qb_valid, qb_ready;
    pfdl_item_t fq_item, qb_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_x_reg <= '0;
            trig_y_reg <= '0;
            trig_z_reg <= '0;
            radius_reg <= COORD_W'(256);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TRIGGER_X:      trig_x_reg <= cfg_data;
                REG_TRIGGER_Y:      trig_y_reg <= cfg_data;
                REG_TRIGGER_Z:      trig_z_reg <= cfg_data;
                REG_TRIGGER_RADIUS: radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        r2_reg <= radius_reg * radius_reg;
    end

    pfdl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .fx        (s_fixture_x),
        .fy        (s_fixture_y),
        .fz        (s_fixture_z),
        .fch       (s_fixture_channel),
        .tx        (trig_x_reg),
        .ty        (trig_y_reg),
        .tz        (trig_z_reg),
        .radius    (radius_reg),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_item  (fq_item)
    );

    pfdl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    pfdl_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (qb_valid),
        .in_ready    (qb_ready),
        .in_item     (qb_item),
        .r2          (r2_reg),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_channel (m_out_channel),
        .out_level   (m_dmx_level)
    );

endmodule
